// ----- src/lprr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers of the length-prefixed record ring
package lprr_pkg;

  // ring geometry (ring size and alignment are powers of two)
  localparam int unsigned RING_BYTES   = 4096;
  localparam int unsigned RECORD_ALIGN = 32;
  localparam int unsigned HDR_BYTES    = 4;
  localparam int unsigned PTR_W        = $clog2(RING_BYTES);
  localparam int unsigned ALIGN_W      = $clog2(RECORD_ALIGN);

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 3;

  // footprint width and width used to compare footprint with free space
  localparam int unsigned FP_W  = LEN_W + 1;
  localparam int unsigned CMP_W = (FP_W > PTR_W) ? FP_W : PTR_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BEGIN = 3'd0,
    CMD_PUSH_BYTE  = 3'd1,
    CMD_PEEK_BYTE  = 3'd2,
    CMD_POP        = 3'd3,
    CMD_CLEAR      = 3'd4
  } lprr_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NOREC   = 3'd3,
    ST_RANGE   = 3'd4
  } lprr_status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  record_length;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  read_offset;
  } lprr_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  head_length;
  } lprr_out_t;

  // one access to the byte store
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } lprr_mem_req_t;

  // header plus payload, rounded up to the record alignment
  function automatic logic [FP_W-1:0] footprint(logic [LEN_W-1:0] len);
    logic [FP_W-1:0] sum;
    sum = FP_W'(len) + FP_W'(HDR_BYTES + RECORD_ALIGN - 1);
    return sum & ~FP_W'(RECORD_ALIGN - 1);
  endfunction

  // little-endian header byte of a record length
  function automatic logic [BYTE_W-1:0] hdr_byte(logic [LEN_W-1:0] len, logic [1:0] idx);
    logic [4*BYTE_W-1:0] word;
    word = (4*BYTE_W)'(len);
    return word[BYTE_W*idx +: BYTE_W];
  endfunction

endpackage

// ----- src/lprr_ram.sv -----
`timescale 1ns / 1ps
// single-port synchronous ram with registered read data
module lprr_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lprr_seq.sv -----
`timescale 1ns / 1ps
// command sequencer: pointer state and reads and writes of the byte store
module lprr_seq import lprr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lprr_in_t          in_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output lprr_out_t         res_data_o,
  output lprr_mem_req_t     mem_req_o,
  input  logic [BYTE_W-1:0] mem_rdata_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_HDRWR = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_HL0   = 9'b000010000,
    S_HL1   = 9'b000100000,
    S_HL2   = 9'b001000000,
    S_PEEK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  pend_q, pend_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              open_q, open_d;
  logic              final_q, final_d;
  logic [1:0]        cnt_q, cnt_d;

  lprr_in_t          item_q, item_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [BYTE_W-1:0] rbyte_q, rbyte_d;
  logic [LEN_W-1:0]  hlen_q, hlen_d;
  logic [BYTE_W-1:0] lo_q, lo_d;

  logic [FP_W-1:0]     push_fp;
  logic [PTR_W-1:0]    free_bytes;
  logic [2*BYTE_W-1:0] hdr_word;
  logic [LEN_W-1:0]    hdr_len;
  logic [FP_W-1:0]     hdr_fp;

  // free space keeps one byte empty
  assign push_fp    = footprint(item_q.record_length);
  assign free_bytes = head_q - tail_q - PTR_W'(1);
  assign hdr_word   = {mem_rdata_i, lo_q};
  assign hdr_len    = hdr_word[LEN_W-1:0];
  assign hdr_fp     = footprint(hdr_len);

  // next state and memory access
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    wr_d      = wr_q;
    pend_d    = pend_q;
    left_d    = left_q;
    open_d    = open_q;
    final_d   = final_q;
    cnt_d     = cnt_q;
    item_d    = item_q;
    status_d  = status_q;
    rbyte_d   = rbyte_q;
    hlen_d    = hlen_q;
    lo_d      = lo_q;
    mem_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d   = in_data_i;
          status_d = ST_OK;
          rbyte_d  = '0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_CHK;
        case (item_q.cmd)
          CMD_PUSH_BEGIN: begin
            if (CMP_W'(push_fp) > CMP_W'(free_bytes)) begin
              status_d = ST_NOSPACE;
            end else begin
              cnt_d   = '0;
              state_d = S_HDRWR;
            end
          end
          CMD_PUSH_BYTE: begin
            if (!open_q || left_q == '0) begin
              status_d = ST_NOREC;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = wr_q;
              mem_req_o.wdata = item_q.data_byte;
              wr_d            = wr_q + PTR_W'(1);
              left_d          = left_q - LEN_W'(1);
              // last payload byte commits the record
              if (left_q == LEN_W'(1)) begin
                tail_d = pend_q;
                open_d = 1'b0;
              end
            end
          end
          CMD_PEEK_BYTE, CMD_POP: begin
            if (head_q == tail_q) begin
              status_d = ST_EMPTY;
            end else begin
              final_d = 1'b0;
              state_d = S_HL0;
            end
          end
          CMD_CLEAR: begin
            head_d = '0;
            tail_d = '0;
            wr_d   = '0;
            pend_d = '0;
            left_d = '0;
            open_d = 1'b0;
          end
          default: begin
            state_d = S_CHK;
          end
        endcase
      end
      S_HDRWR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = tail_q + PTR_W'(cnt_q);
        mem_req_o.wdata = hdr_byte(item_q.record_length, cnt_q);
        cnt_d           = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          wr_d    = tail_q + PTR_W'(HDR_BYTES);
          pend_d  = tail_q + PTR_W'(push_fp);
          left_d  = item_q.record_length;
          state_d = S_CHK;
          // zero-length record commits at once
          if (item_q.record_length == '0) begin
            tail_d = tail_q + PTR_W'(push_fp);
            open_d = 1'b0;
          end else begin
            open_d = 1'b1;
          end
        end
      end
      S_CHK: begin
        if (head_q == tail_q) begin
          hlen_d  = '0;
          state_d = S_DONE;
        end else begin
          final_d = 1'b1;
          state_d = S_HL0;
        end
      end
      S_HL0: begin
        mem_req_o.addr = head_q;
        state_d        = S_HL1;
      end
      S_HL1: begin
        mem_req_o.addr = head_q + PTR_W'(1);
        lo_d           = mem_rdata_i;
        state_d        = S_HL2;
      end
      S_HL2: begin
        if (final_q) begin
          hlen_d  = hdr_len;
          state_d = S_DONE;
        end else if (item_q.cmd == CMD_PEEK_BYTE) begin
          hlen_d = hdr_len;
          if (item_q.read_offset >= hdr_len) begin
            status_d = ST_RANGE;
            state_d  = S_DONE;
          end else begin
            mem_req_o.addr = head_q + PTR_W'(HDR_BYTES) + PTR_W'(item_q.read_offset);
            state_d        = S_PEEK;
          end
        end else begin
          // pop: skip the head record footprint
          head_d  = head_q + PTR_W'(hdr_fp);
          state_d = S_CHK;
        end
      end
      S_PEEK: begin
        rbyte_d = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      wr_q    <= '0;
      pend_q  <= '0;
      left_q  <= '0;
      open_q  <= 1'b0;
      final_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      wr_q    <= wr_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
      open_q  <= open_d;
      final_q <= final_d;
      cnt_q   <= cnt_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    rbyte_q  <= rbyte_d;
    hlen_q   <= hlen_d;
    lo_q     <= lo_d;
  end

  assign in_ready_o              = (state_q == S_IDLE);
  assign res_valid_o             = (state_q == S_DONE);
  assign res_data_o.status       = status_q;
  assign res_data_o.read_byte    = rbyte_q;
  assign res_data_o.head_length  = hlen_q;

  // store writes only while executing a push
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_EXEC || state_q == S_HDRWR))
    else $error("store written outside a push");

  // a closed record has no bytes outstanding
  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (left_q == '0))
    else $error("bytes outstanding with no open record");

  // an empty ring reports zero head length
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && head_q == tail_q) |-> (hlen_q == '0))
    else $error("nonzero head length on empty ring");

endmodule

// ----- src/length_prefixed_record_ring.sv -----
`timescale 1ns / 1ps
// Length-prefixed record ring: a 4096-byte ring of records, each a 4-byte
// little-endian length header plus payload, occupying a footprint rounded up
// to 32 bytes. Commands arrive one beat at a time and every command gives one
// result beat (status, peeked byte, head record length). The block handles one
// command at a time through a single-port byte ram with registered read data.
// The ram port shapes each command: push_begin writes its four header bytes
// one a cycle, peek and pop read the two low header bytes of the head record,
// and every command ends with a header read of the head record when the ring
// is not empty (pop reads two headers). A finished result waits in the output
// register while the next command is taken. No clearing pass is needed after
// reset.
module length_prefixed_record_ring import lprr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lprr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lprr_out_t out_data_o
);

  lprr_mem_req_t     mem_req;
  logic [BYTE_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  lprr_out_t         res_data;
  logic              out_valid_q, out_valid_d;
  lprr_out_t         out_data_q;

  // command sequencer
  lprr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // byte store
  lprr_ram #(
    .DEPTH (RING_BYTES),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sequencer is busy the cycle after a command beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("command taken while sequencer busy");

  // a handed-over result is shown on the next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_o)
    else $error("result beat lost");

endmodule
